/* design/uds_request_download_parser_assert.svh */
// ----------------------------------------------------------------------------
// uds_request_download_parser_assert.svh
// Assertion macros shared by the RequestDownload parser modules.
// ----------------------------------------------------------------------------
`ifndef UDS_REQUEST_DOWNLOAD_PARSER_ASSERT_SVH
`define UDS_REQUEST_DOWNLOAD_PARSER_ASSERT_SVH

// Check a property on every rising edge of clk outside of reset.
`define UDS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that prop holds in the cycle after cond, on every rising edge of clk outside of reset.
`define UDS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* design/uds_rdp_pkg.sv */
// ----------------------------------------------------------------------------
// uds_rdp_pkg
// Types and constants of the RequestDownload parser.
// ----------------------------------------------------------------------------
package uds_rdp_pkg;

	localparam int MAX_FIELD_BYTES = 4;

	localparam logic [15:0] RESET_BLOCK_LEN = 16'd514;
	localparam logic [3:0]  BYTE_COUNT_MAX  = 4'd15;
	localparam logic [3:0]  HEADER_BYTES    = 4'd3;
	localparam logic [3:0]  POS_FORMAT_ID   = 4'd1;
	localparam logic [3:0]  POS_LENGTH_FMT  = 4'd2;

	localparam logic [7:0] CODE_OK     = 8'h74;
	localparam logic [7:0] CODE_FORMAT = 8'h13;
	localparam logic [7:0] CODE_RANGE  = 8'h31;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_RANGE  = 2'd2
	} status_t;

	// Packed so that status lands in the lowest bits.
	typedef struct packed {
		logic [15:0] granted_block_length;
		logic [31:0] transfer_size;
		logic [31:0] start_address;
		logic [7:0]  response_code;
		status_t     status;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

/* design/uds_request_download_parser.sv */
// ----------------------------------------------------------------------------
// uds_request_download_parser
// RequestDownload message parser: byte stream in, one verdict per message.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle on the slave stream while
// s_axis_tready is high, tlast on the final byte, and returns one verdict per
// message on the master stream. Bytes pass through an input register and
// then update the field state; only a final byte needs room in the result
// register, so while a verdict waits on m_axis_tready the block still takes
// bytes until a final byte reaches the input register. The block length is
// written via cfg_we/cfg_wdata, by the user between messages; not enforced.
// ----------------------------------------------------------------------------
module uds_request_download_parser import uds_rdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// data_byte
	input  logic [7:0]         s_axis_tdata,
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// status, response_code, start_address, transfer_size, granted_block_length
	output logic [TDATA_W-1:0] m_axis_tdata
);

	logic [15:0] max_block_length_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        can_load;
	logic        take;
	result_t     verdict;

	// a final byte advances only when the result register has room
	assign take          = valid_s1 && (!last_s1 || can_load);
	assign s_axis_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_block_length_q <= RESET_BLOCK_LEN;
			valid_s1           <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_block_length_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	uds_rdp_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.data_byte        (byte_s1),
		.last_byte        (last_s1),
		.max_block_length (max_block_length_q),
		.verdict          (verdict)
	);

	uds_rdp_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take && last_s1),
		.result        (verdict),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

/* design/uds_rdp_parse.sv */
// ----------------------------------------------------------------------------
// uds_rdp_parse
// Message field state and verdict logic, one byte per cycle while take is high.
// ----------------------------------------------------------------------------
`include "uds_request_download_parser_assert.svh"

module uds_rdp_parse import uds_rdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [15:0] max_block_length,
	output result_t     verdict
);

	logic [3:0]  byte_count_q;
	logic [7:0]  format_id_q;
	logic [7:0]  length_format_q;
	logic [31:0] address_accum_q;
	logic [31:0] size_accum_q;

	logic [3:0]  count_n;
	logic [7:0]  format_n;
	logic [7:0]  length_fmt_n;
	logic [31:0] address_n;
	logic [31:0] size_n;
	logic [3:0]  field_pos;
	logic [3:0]  addr_nib;
	logic [3:0]  size_nib;
	logic [4:0]  expected_len;
	logic        nib_bad;
	status_t     status;

	assign field_pos = byte_count_q - HEADER_BYTES;

	always_comb begin
		format_n     = format_id_q;
		length_fmt_n = length_format_q;
		address_n    = address_accum_q;
		size_n       = size_accum_q;
		if (byte_count_q == POS_FORMAT_ID) begin
			format_n = data_byte;
		end else if (byte_count_q == POS_LENGTH_FMT) begin
			length_fmt_n = data_byte;
		end else if (byte_count_q >= HEADER_BYTES) begin
			// route to the address until its byte count is used up
			if (field_pos < length_format_q[3:0]) begin
				address_n = {address_accum_q[23:0], data_byte};
			end else begin
				size_n = {size_accum_q[23:0], data_byte};
			end
		end
		count_n = (byte_count_q < BYTE_COUNT_MAX) ? byte_count_q + 4'd1 : byte_count_q;
	end

	assign addr_nib     = length_fmt_n[3:0];
	assign size_nib     = length_fmt_n[7:4];
	assign expected_len = {1'b0, addr_nib} + {1'b0, size_nib} + {1'b0, HEADER_BYTES};
	assign nib_bad      = (addr_nib == 4'd0) || (size_nib == 4'd0) ||
	                      (addr_nib > 4'(MAX_FIELD_BYTES)) || (size_nib > 4'(MAX_FIELD_BYTES));

	always_comb begin
		priority if (count_n < HEADER_BYTES) begin
			status = STATUS_FORMAT;
		end else if (format_n != 8'h00) begin
			status = STATUS_RANGE;
		end else if (nib_bad) begin
			status = STATUS_RANGE;
		end else if ({1'b0, count_n} != expected_len) begin
			status = STATUS_FORMAT;
		end else if (size_n == 32'd0) begin
			status = STATUS_RANGE;
		end else begin
			status = STATUS_OK;
		end
	end

	always_comb begin
		verdict                      = '0;
		verdict.status               = status;
		unique case (status)
			STATUS_OK: begin
				verdict.response_code        = CODE_OK;
				verdict.start_address        = address_n;
				verdict.transfer_size        = size_n;
				verdict.granted_block_length = max_block_length;
			end
			STATUS_FORMAT: verdict.response_code = CODE_FORMAT;
			default:       verdict.response_code = CODE_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			format_id_q     <= '0;
			length_format_q <= '0;
			address_accum_q <= '0;
			size_accum_q    <= '0;
		end else if (take) begin
			if (last_byte) begin
				// clear for the next message
				byte_count_q    <= '0;
				format_id_q     <= '0;
				length_format_q <= '0;
				address_accum_q <= '0;
				size_accum_q    <= '0;
			end else begin
				byte_count_q    <= count_n;
				format_id_q     <= format_n;
				length_format_q <= length_fmt_n;
				address_accum_q <= address_n;
				size_accum_q    <= size_n;
			end
		end
	end

	`UDS_ASSERT_NEXT(a_clear_after_last, take && last_byte,
		byte_count_q == 4'd0 && size_accum_q == 32'd0, "state not cleared after final byte")
	`UDS_ASSERT_NEXT(a_count_advance, take && !last_byte && byte_count_q != BYTE_COUNT_MAX,
		byte_count_q == 4'($past(byte_count_q) + 4'd1), "byte count did not advance")
	`UDS_ASSERT(a_ok_has_size, status != STATUS_OK || size_n != 32'd0,
		"accepted verdict with zero size")

endmodule

/* design/uds_rdp_out.sv */
// ----------------------------------------------------------------------------
// uds_rdp_out
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
`include "uds_request_download_parser_assert.svh"

module uds_rdp_out import uds_rdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  result_t            result,
	output logic               can_load,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// status, response_code, start_address, transfer_size, granted_block_length
	output logic [TDATA_W-1:0] m_axis_tdata
);

	logic    valid_q;
	result_t result_q;

	assign can_load      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_q <= result;
		end
	end

	`UDS_ASSERT(a_no_overwrite, !(valid_q && !m_axis_tready && load),
		"result loaded over a pending transaction")

endmodule
